FILE: sv/ssc_pkg.sv
// Package with shared types, constants and the Salsa quarter-round helpers.
`timescale 1ns / 1ps
package ssc_pkg;

  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned RoundCntW = $clog2(2 * DoubleRounds + 1);

  localparam logic [2:0] RegKeyA  = 3'd0;
  localparam logic [2:0] RegKeyB  = 3'd1;
  localparam logic [2:0] RegKeyC  = 3'd2;
  localparam logic [2:0] RegKeyD  = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;
  localparam logic [2:0] RegLong  = 3'd5;

  localparam logic [31:0] LongConst0  = 32'h25119779;
  localparam logic [31:0] LongConst1  = 32'h88040785;
  localparam logic [31:0] LongConst2  = 32'h79777765;
  localparam logic [31:0] LongConst3  = 32'h11FADE99;
  localparam logic [31:0] ShortConst0 = 32'h3C2D1E0F;
  localparam logic [31:0] ShortConst1 = 32'h78695A4B;
  localparam logic [31:0] ShortConst2 = 32'h89553421;
  localparam logic [31:0] ShortConst3 = 32'hCCBBAA79;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic load;
    logic round;
    logic odd;
    logic finish;
  } dp_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] nb, nc, nd, na;
    nb = b ^ rotl(a + d, 7);
    nc = c ^ rotl(nb + a, 9);
    nd = d ^ rotl(nc + nb, 13);
    na = a ^ rotl(nd + nc, 18);
    quarter = {na, nb, nc, nd};
  endfunction

endpackage

FILE: sv/ssc_if.sv
// Valid/ready channel interfaces for data and configuration beats.
`timescale 1ns / 1ps
interface ssc_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_data;
  logic       last;
  modport source (output valid, output byte_data, output last, input ready);
  modport sink (input valid, input byte_data, input last, output ready);
endinterface

interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/ssc_datapath.sv
// Datapath: key store, block counter, round state, keystream block and byte output.
`timescale 1ns / 1ps
module ssc_datapath import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  dp_cmd_t     cmd_i,
  input  logic        out_load_i,
  input  logic [5:0]  pos_i,
  input  logic [7:0]  msg_i,
  input  logic        last_i,
  output logic [7:0]  cipher_o,
  output logic        last_o
);
  logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q, nonce_q, ctr_q;
  logic        long_q;
  words_t      init, w_q, w_d;
  words_t      ks_q;
  logic [7:0]  cipher_q;
  logic        last_q;
  logic [63:0] k3, k4;
  logic [127:0] q0, q1, q2, q3;

  always_comb begin
    k3 = long_q ? key_c_q : key_a_q;
    k4 = long_q ? key_d_q : key_b_q;
    init[0]  = long_q ? LongConst0 : ShortConst0;
    init[1]  = key_a_q[31:0];
    init[2]  = key_a_q[63:32];
    init[3]  = key_b_q[31:0];
    init[4]  = key_b_q[63:32];
    init[5]  = long_q ? LongConst1 : ShortConst1;
    init[6]  = nonce_q[31:0];
    init[7]  = nonce_q[63:32];
    init[8]  = ctr_q[31:0];
    init[9]  = ctr_q[63:32];
    init[10] = long_q ? LongConst2 : ShortConst2;
    init[11] = k3[31:0];
    init[12] = k3[63:32];
    init[13] = k4[31:0];
    init[14] = k4[63:32];
    init[15] = long_q ? LongConst3 : ShortConst3;
  end

  // Column round on even steps, row round on odd steps.
  always_comb begin
    w_d = w_q;
    if (!cmd_i.odd) begin
      q0 = quarter(w_q[0], w_q[4], w_q[8], w_q[12]);
      q1 = quarter(w_q[5], w_q[9], w_q[13], w_q[1]);
      q2 = quarter(w_q[10], w_q[14], w_q[2], w_q[6]);
      q3 = quarter(w_q[15], w_q[3], w_q[7], w_q[11]);
      {w_d[0], w_d[4], w_d[8], w_d[12]}  = q0;
      {w_d[5], w_d[9], w_d[13], w_d[1]}  = q1;
      {w_d[10], w_d[14], w_d[2], w_d[6]} = q2;
      {w_d[15], w_d[3], w_d[7], w_d[11]} = q3;
    end else begin
      q0 = quarter(w_q[0], w_q[1], w_q[2], w_q[3]);
      q1 = quarter(w_q[5], w_q[6], w_q[7], w_q[4]);
      q2 = quarter(w_q[10], w_q[11], w_q[8], w_q[9]);
      q3 = quarter(w_q[15], w_q[12], w_q[13], w_q[14]);
      {w_d[0], w_d[1], w_d[2], w_d[3]}     = q0;
      {w_d[5], w_d[6], w_d[7], w_d[4]}     = q1;
      {w_d[10], w_d[11], w_d[8], w_d[9]}   = q2;
      {w_d[15], w_d[12], w_d[13], w_d[14]} = q3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= '0;
      key_b_q <= '0;
      key_c_q <= '0;
      key_d_q <= '0;
      nonce_q <= '0;
      long_q  <= 1'b1;
      ctr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyA:  key_a_q <= cfg_data_i;
        RegKeyB:  key_b_q <= cfg_data_i;
        RegKeyC:  key_c_q <= cfg_data_i;
        RegKeyD:  key_d_q <= cfg_data_i;
        RegNonce: nonce_q <= cfg_data_i;
        RegLong:  long_q  <= cfg_data_i[0];
        default:  ;
      endcase
      if (cfg_idx_i <= RegLong) begin
        ctr_q <= '0;
      end
    end else if (cmd_i.finish) begin
      ctr_q <= ctr_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= init;
    end else if (cmd_i.round) begin
      w_q <= w_d;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= w_q[i] + init[i];
      end
    end
    if (out_load_i) begin
      cipher_q <= msg_i ^ ks_q[pos_i[5:2]][8*pos_i[1:0] +: 8];
      last_q   <= last_i;
    end
  end

  assign cipher_o = cipher_q;
  assign last_o   = last_q;
endmodule

FILE: sv/ssc_ctrl.sv
// Controller: block generation sequence, byte position and output handshake.
`timescale 1ns / 1ps
module ssc_ctrl import ssc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  output logic       out_load_o,
  output logic [5:0] pos_o
);
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRound = 3'b010,
    StFin   = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [RoundCntW-1:0] rnd_q, rnd_d;
  logic [5:0]           pos_q, pos_d;
  logic                 ready_q, ready_d;
  logic                 ov_q, ov_d;
  logic                 take, out_free, cfg_hit;

  assign cfg_hit    = cfg_we_i && (cfg_idx_i <= RegLong);
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && ready_q && out_free;
  assign take       = in_valid_i && in_ready_o;
  assign out_load_o = take;
  assign pos_o      = pos_q;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    pos_d   = pos_q;
    ready_d = ready_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (!ready_q && in_valid_i && !cfg_we_i) begin
          cmd_o.load = 1'b1;
          rnd_d      = '0;
          state_d    = StRound;
        end else if (take) begin
          ov_d  = 1'b1;
          pos_d = pos_q + 6'd1;
          if (pos_q == 6'd63 || in_last_i) begin
            ready_d = 1'b0;
            pos_d   = '0;
          end
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        cmd_o.odd   = rnd_q[0];
        rnd_d       = rnd_q + 1'b1;
        if (rnd_q == RoundCntW'(2 * DoubleRounds - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        ready_d      = 1'b1;
        pos_d        = '0;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cfg_hit) begin
      ready_d = 1'b0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      pos_q   <= '0;
      ready_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      ready_q <= ready_d;
      ov_q    <= ov_d;
    end
  end
endmodule

FILE: sv/salsa20_stream_cipher_unit.sv
// Top level of the Salsa20 stream cipher unit.
`timescale 1ns / 1ps
// Each message beat is XORed with one keystream byte and leaves through a registered
// output stage in the next cycle; one beat is taken per cycle while a block is on
// hand and the output is not held. When no block is ready (after reset, a key, nonce
// or key-length write, the end of a message or 64 used bytes), the next beat waits
// while the shared quarter-round datapath, one round per cycle, makes the next
// 64-byte block. Configure only while idle; such writes zero the block counter.
module salsa20_stream_cipher_unit import ssc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  ssc_cfg_if.sink  cfg,
  ssc_data_if.sink din,
  ssc_data_if.source dout
);
  dp_cmd_t    cmd;
  logic       out_load;
  logic [5:0] pos;
  logic       cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  ssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg.index),
    .in_valid_i  (din.valid),
    .in_last_i   (din.last),
    .in_ready_o  (din.ready),
    .out_valid_o (dout.valid),
    .out_ready_i (dout.ready),
    .cmd_o       (cmd),
    .out_load_o  (out_load),
    .pos_o       (pos)
  );

  ssc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg.index),
    .cfg_data_i (cfg.data),
    .cmd_i      (cmd),
    .out_load_i (out_load),
    .pos_i      (pos),
    .msg_i      (din.byte_data),
    .last_i     (din.last),
    .cipher_o   (dout.byte_data),
    .last_o     (dout.last)
  );
endmodule

FILE: sv/ssc_checker.sv
// Port-level checker for the stream cipher unit, with its bind.
`timescale 1ns / 1ps
module ssc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic in_last,
  input logic out_last
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid) else $error("accepted beat gave no output");
  a_last_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_last == $past(in_last)) else $error("last flag lost");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while output full");
endmodule

bind salsa20_stream_cipher_unit ssc_checker u_ssc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .in_last   (din.last),
  .out_last  (dout.last)
);

FILE: verif/tb.sv
// Self-checking testbench for the Salsa20 stream cipher unit with a keystream scoreboard.
`timescale 1ns / 1ps
class keystream_scoreboard;
  logic [63:0] key_a, key_b, key_c, key_d, nonce;
  logic        long_key;
  logic [63:0] blk_count;
  logic [7:0]  ks_bytes[64];
  logic [5:0]  pos;
  logic        have_block;
  logic [31:0] w[16];
  logic [8:0]  cipher_q[$];
  int          mismatches;
  int          beats_in;
  int          beats_out;
  int          blocks_made;
  int          short_blocks;

  function new();
    key_a = '0; key_b = '0; key_c = '0; key_d = '0; nonce = '0;
    long_key = 1'b1;
    blk_count = '0; pos = '0; have_block = 1'b0;
    mismatches = 0; beats_in = 0; beats_out = 0; blocks_made = 0; short_blocks = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      ssc_pkg::RegKeyA:  key_a = val;
      ssc_pkg::RegKeyB:  key_b = val;
      ssc_pkg::RegKeyC:  key_c = val;
      ssc_pkg::RegKeyD:  key_d = val;
      ssc_pkg::RegNonce: nonce = val;
      ssc_pkg::RegLong:  long_key = val[0];
      default: return;
    endcase
    blk_count = '0; pos = '0; have_block = 1'b0;
  endfunction

  function logic [31:0] rot(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function void mix(int a, int b, int c, int d);
    w[b] = w[b] ^ rot(w[a] + w[d], 7);
    w[c] = w[c] ^ rot(w[b] + w[a], 9);
    w[d] = w[d] ^ rot(w[c] + w[b], 13);
    w[a] = w[a] ^ rot(w[d] + w[c], 18);
  endfunction

  function void make_keystream();
    logic [31:0] init[16];
    logic [63:0] k3, k4;
    logic [31:0] sum;
    k3 = long_key ? key_c : key_a;
    k4 = long_key ? key_d : key_b;
    init[0]  = long_key ? ssc_pkg::LongConst0 : ssc_pkg::ShortConst0;
    init[5]  = long_key ? ssc_pkg::LongConst1 : ssc_pkg::ShortConst1;
    init[10] = long_key ? ssc_pkg::LongConst2 : ssc_pkg::ShortConst2;
    init[15] = long_key ? ssc_pkg::LongConst3 : ssc_pkg::ShortConst3;
    {init[2], init[1]}   = key_a;
    {init[4], init[3]}   = key_b;
    {init[7], init[6]}   = nonce;
    {init[9], init[8]}   = blk_count;
    {init[12], init[11]} = k3;
    {init[14], init[13]} = k4;
    w = init;
    for (int r = 0; r < ssc_pkg::DoubleRounds; r++) begin
      mix(0, 4, 8, 12);  mix(5, 9, 13, 1);  mix(10, 14, 2, 6);  mix(15, 3, 7, 11);
      mix(0, 1, 2, 3);   mix(5, 6, 7, 4);   mix(10, 11, 8, 9);  mix(15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = w[i] + init[i];
      for (int j = 0; j < 4; j++) ks_bytes[4 * i + j] = sum[8 * j +: 8];
    end
    blk_count = blk_count + 64'd1;
    blocks_made++;
    if (!long_key) short_blocks++;
  endfunction

  function void note_beat(logic [7:0] msg, logic last);
    if (!have_block) begin
      make_keystream();
      have_block = 1'b1;
      pos = '0;
    end
    cipher_q.push_back({msg ^ ks_bytes[pos], last});
    pos = pos + 6'd1;
    if (pos == 6'd0) have_block = 1'b0;
    if (last) begin
      have_block = 1'b0;
      pos = '0;
    end
    beats_in++;
  endfunction

  function void check_beat(logic [7:0] cb, logic last);
    logic [8:0] want;
    beats_out++;
    if (cipher_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("output beat %0d arrived with nothing pending", beats_out);
      return;
    end
    want = cipher_q.pop_front();
    if (want !== {cb, last}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                 beats_out, want[8:1], want[0], cb, last);
    end
  endfunction
endclass

module tb;
  import ssc_pkg::*;

  logic clk_i;
  logic rst_ni;
  ssc_cfg_if  cfg_ch ();
  ssc_data_if din_ch ();
  ssc_data_if dout_ch ();

  keystream_scoreboard sb;
  bit no_idle;
  bit hold_done;
  bit pause_done;
  int hold_cycles;
  int sent;

  salsa20_stream_cipher_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .din    (din_ch),
    .dout   (dout_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout waiting for the unit");
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (din_ch.valid && din_ch.ready) sb.note_beat(din_ch.byte_data, din_ch.last);
      if (dout_ch.valid && dout_ch.ready) sb.check_beat(dout_ch.byte_data, dout_ch.last);
    end
  end

  // The receiver either follows a long hold request or, unless no_idle is set, idles at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      dout_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      dout_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      dout_ch.ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  task automatic send_beat(logic [7:0] b, logic last);
    while (!no_idle && $urandom_range(99) < 29) begin
      din_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    din_ch.valid     <= 1'b1;
    din_ch.byte_data <= b;
    din_ch.last      <= last;
    do @(posedge clk_i); while (!din_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_message(int len, bit extremes);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
      send_beat(b, i == len - 1);
    end
  endtask

  task automatic drain();
    din_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.cipher_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_setting(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                              logic [63:0] d, logic [63:0] n, logic lk);
    drain();
    cfg_write(RegKeyA, a);
    cfg_write(RegKeyB, b);
    cfg_write(RegKeyC, c);
    cfg_write(RegKeyD, d);
    cfg_write(RegNonce, n);
    cfg_write(RegLong, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFFE | 64'(lk));
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 20);
    if (r < 95) return $urandom_range(60, 70);
    return $urandom_range(120, 135);
  endfunction

  initial begin
    sb = new();
    no_idle = 1'b0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    hold_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    din_ch.valid = 1'b0;
    din_ch.byte_data = '0;
    din_ch.last = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values first, then extreme keys in both key lengths.
    send_message(1, 1'b1);
    send_message(3, 1'b1);
    load_setting('1, '1, '1, '1, '1, 1'b1);
    send_message(2, 1'b1);
    load_setting('0, '0, '0, '0, '0, 1'b0);
    send_message(2, 1'b1);
    load_setting('1, '1, '0, '0, '1, 1'b0);
    send_message(2, 1'b1);
    drain();
    cfg_write(3'd6, '1);
    cfg_write(3'd7, rnd64());
    send_message(1, 1'b1);

    while (sent < 1750) begin
      if ($urandom_range(5) == 0)
        load_setting(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 1'($urandom));
      no_idle = (sent > 700 && sent < 900);
      if (sent > 400 && !hold_done && hold_cycles == 0) begin
        hold_cycles <= 300;
        hold_done = 1'b1;
      end
      if (sent > 1200 && !pause_done) begin
        pause_done = 1'b1;
        din_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (sb.cipher_q.size() != 0) @(negedge clk_i);
      end
      send_message(pick_len(), $urandom_range(19) == 0);
    end

    din_ch.valid <= 1'b0;
    while (sb.cipher_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("%0d beats in, %0d beats out, %0d keystream blocks (%0d with 128-bit keys)",
             sb.beats_in, sb.beats_out, sb.blocks_made, sb.short_blocks);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/ssc_pkg.sv
sv/ssc_if.sv
sv/ssc_datapath.sv
sv/ssc_ctrl.sv
sv/salsa20_stream_cipher_unit.sv
sv/ssc_checker.sv
verif/tb.sv
